// File: rtl/core/ltt_pkg.sv
package ltt_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned STR_LEN = 26;
  localparam int unsigned POS_SAT = 27;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] MONTH_NONE = 4'd0;
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_DEC  = 4'd12;

  localparam logic [11:0] YEAR_BASE_M1  = 12'd1999;
  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [23:0] TICKS_PER_SEC = 24'd10000000;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [59:0] ticks;
  } out_word_t;

  typedef struct packed {
    logic       pre_ok;
    logic [5:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } fields_t;

  function automatic logic digit_ok(input logic [7:0] c, input logic [7:0] max_c);
    return (c >= CH_ZERO) && (c <= max_c);
  endfunction

  function automatic logic [3:0] month_code(input logic [15:0] prefix,
                                            input logic [7:0] c);
    unique case ({prefix, c})
      "Jan": return 4'd1;
      "Feb": return 4'd2;
      "Mar": return 4'd3;
      "Apr": return 4'd4;
      "May": return 4'd5;
      "Jun": return 4'd6;
      "Jul": return 4'd7;
      "Aug": return 4'd8;
      "Sep": return 4'd9;
      "Oct": return 4'd10;
      "Nov": return 4'd11;
      "Dec": return 4'd12;
      default: return MONTH_NONE;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month);
    unique case (month)
      4'd2:                     return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
      default:                  return 5'd31;
    endcase
  endfunction

  // Days in a common year before the first of the month.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    unique case (month)
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// File: rtl/core/log_timestamp_to_ticks_unit.sv
// Parses a timestamp of the form DD/Mon/YYYY:HH:MM:SS +ZZZZ, one character per input word,
// and returns one result word for each word marked last_char: valid_res and the time in
// 100-ns ticks since 0001-01-01, or zero ticks when the string is malformed. One character
// can be taken every cycle while in_stall is low. The result word passes through the field
// capture register and the finishing pipeline (day count, seconds multiply, split tick
// multiply and final add) before it appears on the output. Up to five results queue in
// that pipeline, so input keeps flowing while a result waits; the input stalls only once
// all five places are held behind a stalled output.
module log_timestamp_to_ticks_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ltt_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ltt_pkg::out_word_t  out_data
);

  localparam logic [4:0] P_DAY_HI  = 5'd0;
  localparam logic [4:0] P_DAY_LO  = 5'd1;
  localparam logic [4:0] P_SLASH1  = 5'd2;
  localparam logic [4:0] P_MON1    = 5'd3;
  localparam logic [4:0] P_MON2    = 5'd4;
  localparam logic [4:0] P_MON3    = 5'd5;
  localparam logic [4:0] P_SLASH2  = 5'd6;
  localparam logic [4:0] P_YEAR_HI = 5'd9;
  localparam logic [4:0] P_YEAR_LO = 5'd10;
  localparam logic [4:0] P_COLON1  = 5'd11;
  localparam logic [4:0] P_HOUR_HI = 5'd12;
  localparam logic [4:0] P_HOUR_LO = 5'd13;
  localparam logic [4:0] P_COLON2  = 5'd14;
  localparam logic [4:0] P_MIN_HI  = 5'd15;
  localparam logic [4:0] P_MIN_LO  = 5'd16;
  localparam logic [4:0] P_COLON3  = 5'd17;
  localparam logic [4:0] P_SEC_HI  = 5'd18;
  localparam logic [4:0] P_SEC_LO  = 5'd19;
  localparam logic [4:0] P_SPACE   = 5'd20;

  localparam logic [ltt_pkg::POS_W-1:0] POS_SAT_C  = ltt_pkg::POS_W'(ltt_pkg::POS_SAT);
  localparam logic [ltt_pkg::POS_W-1:0] POS_LAST_C = ltt_pkg::POS_W'(ltt_pkg::STR_LEN - 1);

  // Parse state.
  logic [ltt_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic        fail_r, fail_nxt;
  logic [5:0]  day_r, day_nxt;
  logic [15:0] prefix_r, prefix_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [6:0]  year_r, year_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;

  // Finishing pipeline.
  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  ltt_pkg::fields_t  s1_r, s1_nxt;
  logic              s2_ok_r, s3_ok_r, s4_ok_r;
  logic [19:0]       s2_days_r, s2_days_nxt;
  logic [16:0]       s2_sod_r, s2_sod_nxt;
  logic              s2_ok_nxt;
  logic [36:0]       s3_secs_r;
  logic [55:0]       s4_plo_r;
  logic [27:0]       s4_phi_r;
  ltt_pkg::out_word_t out_r;

  logic [7:0] c;
  logic       accept;
  logic       rdy_out, rdy4, rdy3, rdy2, rdy1;

  assign c      = in_data.character;
  assign accept = in_valid && !in_stall;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy4     = !s4_v_r || rdy_out;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_stall = !rdy1;

  always_comb begin
    fail_nxt   = fail_r;
    day_nxt    = day_r;
    prefix_nxt = prefix_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    pos_nxt    = (pos_r < POS_SAT_C) ? pos_r + 1'b1 : pos_r;
    case (pos_r) inside
      P_DAY_HI: begin
        day_nxt = 6'd0;
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_THREE)) day_nxt = 6'(c[3:0]) * 6'd10;
        else fail_nxt = 1'b1;
      end
      P_DAY_LO: begin
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_NINE)) day_nxt = day_r + 6'(c[3:0]);
        else fail_nxt = 1'b1;
      end
      P_MON1: prefix_nxt = {c, 8'h00};
      P_MON2: prefix_nxt = {prefix_r[15:8], c};
      P_MON3: begin
        month_nxt = ltt_pkg::month_code(prefix_r, c);
        if (month_nxt == ltt_pkg::MONTH_NONE) fail_nxt = 1'b1;
      end
      P_YEAR_HI: begin
        year_nxt = 7'd0;
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_NINE)) year_nxt = 7'(c[3:0]) * 7'd10;
        else fail_nxt = 1'b1;
      end
      P_YEAR_LO: begin
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_NINE)) year_nxt = year_r + 7'(c[3:0]);
        else fail_nxt = 1'b1;
      end
      P_HOUR_HI: begin
        hour_nxt = 5'd0;
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_TWO)) hour_nxt = 5'(c[3:0]) * 5'd10;
        else fail_nxt = 1'b1;
      end
      P_HOUR_LO: begin
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_NINE)) hour_nxt = hour_r + 5'(c[3:0]);
        else fail_nxt = 1'b1;
      end
      P_MIN_HI: begin
        min_nxt = 6'd0;
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_FIVE)) min_nxt = 6'(c[3:0]) * 6'd10;
        else fail_nxt = 1'b1;
      end
      P_MIN_LO: begin
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_NINE)) min_nxt = min_r + 6'(c[3:0]);
        else fail_nxt = 1'b1;
      end
      P_SEC_HI: begin
        sec_nxt = 6'd0;
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_FIVE)) sec_nxt = 6'(c[3:0]) * 6'd10;
        else fail_nxt = 1'b1;
      end
      P_SEC_LO: begin
        if (ltt_pkg::digit_ok(c, ltt_pkg::CH_NINE)) sec_nxt = sec_r + 6'(c[3:0]);
        else fail_nxt = 1'b1;
      end
      P_SLASH1, P_SLASH2: begin
        if (c != ltt_pkg::CH_SLASH) fail_nxt = 1'b1;
      end
      P_COLON1, P_COLON2, P_COLON3: begin
        if (c != ltt_pkg::CH_COLON) fail_nxt = 1'b1;
      end
      P_SPACE: begin
        if (c != ltt_pkg::CH_SPACE) fail_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_char)) begin
      pos_r    <= '0;
      fail_r   <= 1'b0;
      day_r    <= '0;
      prefix_r <= '0;
      month_r  <= ltt_pkg::MONTH_NONE;
      year_r   <= '0;
      hour_r   <= '0;
      min_r    <= '0;
      sec_r    <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      fail_r   <= fail_nxt;
      day_r    <= day_nxt;
      prefix_r <= prefix_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      hour_r   <= hour_nxt;
      min_r    <= min_nxt;
      sec_r    <= sec_nxt;
    end
  end

  // The string has the right length only if its last character sits at the final position.
  always_comb begin
    s1_nxt.pre_ok = !fail_nxt && (pos_r == POS_LAST_C);
    s1_nxt.day    = day_nxt;
    s1_nxt.month  = month_nxt;
    s1_nxt.year   = year_nxt;
    s1_nxt.hour   = hour_nxt;
    s1_nxt.minute = min_nxt;
    s1_nxt.second = sec_nxt;
  end

  // Day count of the whole date. For years 1999 to 2098 the century and 400-year
  // corrections always net to minus fifteen days.
  logic [11:0] s2_year_m1;
  logic        s2_leap;
  logic [4:0]  s2_mlen;
  always_comb begin
    s2_year_m1 = ltt_pkg::YEAR_BASE_M1 + 12'(s1_r.year);
    s2_leap    = (s1_r.year[1:0] == 2'b00);
    s2_mlen    = ltt_pkg::month_len(s1_r.month)
               + ((s2_leap && s1_r.month == ltt_pkg::MONTH_FEB) ? 5'd1 : 5'd0);
    s2_ok_nxt  = s1_r.pre_ok
               && (s1_r.month >= ltt_pkg::MONTH_JAN) && (s1_r.month <= ltt_pkg::MONTH_DEC)
               && (s1_r.day != 6'd0) && (s1_r.day <= {1'b0, s2_mlen})
               && (s1_r.hour <= ltt_pkg::HOUR_MAX);
    s2_days_nxt = 20'(s2_year_m1) * 20'd365 + 20'(s2_year_m1[11:2]) - 20'd15
                + 20'(ltt_pkg::days_before_month(s1_r.month))
                + ((s2_leap && s1_r.month > ltt_pkg::MONTH_FEB) ? 20'd1 : 20'd0)
                + 20'(s1_r.day) - 20'd1;
    s2_sod_nxt  = 17'(s1_r.hour) * 17'd3600 + 17'(s1_r.minute) * 17'd60
                + 17'(s1_r.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    s1_v_r      <= accept && in_data.last_char;
      if (rdy2)    s2_v_r      <= s1_v_r;
      if (rdy3)    s3_v_r      <= s2_v_r;
      if (rdy4)    s4_v_r      <= s3_v_r;
      if (rdy_out) out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) begin
      s2_ok_r   <= s2_ok_nxt;
      s2_days_r <= s2_days_nxt;
      s2_sod_r  <= s2_sod_nxt;
    end
    if (rdy3) begin
      s3_ok_r   <= s2_ok_r;
      s3_secs_r <= 37'(s2_days_r) * 37'(ltt_pkg::SECS_PER_DAY) + 37'(s2_sod_r);
    end
    // The tick product is split at bit 32 of the seconds count and summed in the output register.
    // Only the low 28 bits of the upper part reach the 60-bit tick field.
    if (rdy4) begin
      s4_ok_r  <= s3_ok_r;
      s4_plo_r <= 56'(s3_secs_r[31:0]) * 56'(ltt_pkg::TICKS_PER_SEC);
      s4_phi_r <= 28'(s3_secs_r[36:32]) * 28'(ltt_pkg::TICKS_PER_SEC);
    end
    if (rdy_out) begin
      out_r.valid_res <= s4_ok_r;
      out_r.ticks     <= s4_ok_r ? 60'(s4_plo_r) + {s4_phi_r, 32'h0} : 60'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.valid_res |-> out_r.ticks == 60'd0)
    else $error("invalid result word carries nonzero ticks");

  a_parse_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_char |=> pos_r == '0 && !fail_r)
    else $error("parse state not cleared after last character");

  a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_char |=> s1_v_r)
    else $error("last character did not start a result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned MIN_CHARS    = 700;
  localparam int unsigned MIN_STRINGS  = 20;

  localparam logic [287:0] MONTH_TEXT = "JanFebMarAprMayJunJulAugSepOctNovDec";
  localparam logic [95:0]  MONTH_DAYS = {8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
                                         8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31};
  localparam longint unsigned TICKS_SEC = 64'd10000000;
  localparam longint unsigned DAY_SECS  = 64'd86400;

  typedef enum int unsigned {
    MUT_NONE, MUT_TRUNCATE, MUT_EXTEND, MUT_REPLACE, MUT_CASE
  } mutation_e;

  typedef enum int unsigned {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_e;

  // Index 0 is January.
  function automatic logic [23:0] month_tag(input int unsigned idx);
    return MONTH_TEXT[24 * (11 - idx) +: 24];
  endfunction

  function automatic int unsigned days_in_month(input int unsigned idx, input bit leap);
    return MONTH_DAYS[8 * (11 - idx) +: 8] + ((leap && idx == 1) ? 1 : 0);
  endfunction

  class timestamp_scoreboard;
    logic [4:0]  pos;
    bit          failed;
    logic [5:0]  day_num;
    logic [15:0] name_hi;
    logic [3:0]  month_num;
    logic [6:0]  year_num;
    logic [4:0]  hour_num;
    logic [5:0]  minute_num;
    logic [5:0]  second_num;
    ltt_pkg::out_word_t expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      pos        = '0;
      failed     = 1'b0;
      day_num    = '0;
      name_hi    = '0;
      month_num  = ltt_pkg::MONTH_NONE;
      year_num   = '0;
      hour_num   = '0;
      minute_num = '0;
      second_num = '0;
    endfunction

    function int unsigned digit(input logic [7:0] c, input logic [7:0] hi);
      if (c < ltt_pkg::CH_ZERO || c > hi) begin
        failed = 1'b1;
        return 0;
      end
      return c - ltt_pkg::CH_ZERO;
    endfunction

    function void match_month(input logic [7:0] c);
      month_num = ltt_pkg::MONTH_NONE;
      for (int unsigned k = 0; k < 12; k++) begin
        if ({name_hi, c} == month_tag(k)) month_num = 4'(k + 1);
      end
      if (month_num == ltt_pkg::MONTH_NONE) failed = 1'b1;
    endfunction

    function void take(input logic [7:0] c);
      case (pos)
        5'd0:  day_num = 6'(digit(c, ltt_pkg::CH_THREE) * 10);
        5'd1:  day_num = 6'(day_num + digit(c, ltt_pkg::CH_NINE));
        5'd3:  name_hi = {c, 8'h00};
        5'd4:  name_hi = {name_hi[15:8], c};
        5'd5:  match_month(c);
        5'd9:  year_num = 7'(digit(c, ltt_pkg::CH_NINE) * 10);
        5'd10: year_num = 7'(year_num + digit(c, ltt_pkg::CH_NINE));
        5'd12: hour_num = 5'(digit(c, ltt_pkg::CH_TWO) * 10);
        5'd13: hour_num = 5'(hour_num + digit(c, ltt_pkg::CH_NINE));
        5'd15: minute_num = 6'(digit(c, ltt_pkg::CH_FIVE) * 10);
        5'd16: minute_num = 6'(minute_num + digit(c, ltt_pkg::CH_NINE));
        5'd18: second_num = 6'(digit(c, ltt_pkg::CH_FIVE) * 10);
        5'd19: second_num = 6'(second_num + digit(c, ltt_pkg::CH_NINE));
        5'd2, 5'd6: begin
          if (c != ltt_pkg::CH_SLASH) failed = 1'b1;
        end
        5'd11, 5'd14, 5'd17: begin
          if (c != ltt_pkg::CH_COLON) failed = 1'b1;
        end
        5'd20: begin
          if (c != ltt_pkg::CH_SPACE) failed = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function ltt_pkg::out_word_t finish_string();
      ltt_pkg::out_word_t r;
      int unsigned     m;
      bit              leap;
      longint unsigned y;
      longint unsigned days;
      longint unsigned secs;
      r = '0;
      if (failed || pos != ltt_pkg::STR_LEN) return r;
      if (month_num < ltt_pkg::MONTH_JAN || month_num > ltt_pkg::MONTH_DEC) return r;
      m = month_num - 1;
      leap = (year_num[1:0] == 2'b00);
      if (day_num < 1 || day_num > days_in_month(m, leap) || hour_num > ltt_pkg::HOUR_MAX)
        return r;
      y = 64'(year_num) + 64'd1999;
      days = y * 365 + y / 4 - y / 100 + y / 400;
      // The leap day is already folded into February's length here.
      for (int unsigned k = 0; k < m; k++) days += days_in_month(k, leap);
      days += 64'(day_num) - 1;
      secs = days * DAY_SECS + 64'(hour_num) * 3600 + 64'(minute_num) * 60
           + 64'(second_num);
      r.valid_res = 1'b1;
      r.ticks     = 60'(secs * TICKS_SEC);
      return r;
    endfunction

    function void note_char(input ltt_pkg::in_word_t w);
      if (pos < ltt_pkg::STR_LEN) take(w.character);
      if (pos < ltt_pkg::POS_SAT) pos = pos + 1'b1;
      if (w.last_char) begin
        expected_q.push_back(finish_string());
        clear();
      end
    endfunction

    function void check_result(input ltt_pkg::out_word_t got);
      ltt_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result word: valid_res=%0b ticks=%0d",
                   got.valid_res, got.ticks);
        return;
      end
      want = expected_q.pop_front();
      if (got.valid_res !== want.valid_res || got.ticks !== want.ticks) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result mismatch: expected valid_res=%0b ticks=%0d, got valid_res=%0b ticks=%0d",
                   want.valid_res, want.ticks, got.valid_res, got.ticks);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  ltt_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  ltt_pkg::out_word_t out_data;

  timestamp_scoreboard sb;
  logic [7:0]  text_q[$];
  int unsigned burst_left = 0;
  int unsigned chars_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned cycle_count = 0;
  bit          hold_request = 1'b0;

  log_timestamp_to_ticks_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: a stall pattern whose mode is redrawn at random intervals, plus one
  // long hold-off on request so the result pipeline backs up into the input.
  initial begin : result_sink
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned phase;
    int unsigned hold_left;
    out_stall <= 1'b0;
    mode = STALL_NONE;
    mode_left = 0;
    phase = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((phase % 8) < 3);
        endcase
      end
    end
  end

  // Each word waits for acceptance; bursts of random length are sometimes separated by idle gaps.
  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= '{character: c, last_char: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  task automatic push_pair(input int unsigned n);
    text_q.push_back(8'(ltt_pkg::CH_ZERO + n / 10));
    text_q.push_back(8'(ltt_pkg::CH_ZERO + n % 10));
  endtask

  // With wild set, the century digits and the zone carry arbitrary bytes,
  // since the block never looks at them.
  task automatic make_stamp(input int unsigned dd, input int unsigned mon,
                            input int unsigned yy, input int unsigned hh,
                            input int unsigned mi, input int unsigned ss, input bit wild);
    logic [23:0] tag;
    tag = month_tag(mon);
    text_q.delete();
    push_pair(dd);
    text_q.push_back(ltt_pkg::CH_SLASH);
    text_q.push_back(tag[23:16]);
    text_q.push_back(tag[15:8]);
    text_q.push_back(tag[7:0]);
    text_q.push_back(ltt_pkg::CH_SLASH);
    text_q.push_back(wild ? 8'($urandom_range(0, 255)) : ltt_pkg::CH_TWO);
    text_q.push_back(wild ? 8'($urandom_range(0, 255)) : ltt_pkg::CH_ZERO);
    push_pair(yy);
    text_q.push_back(ltt_pkg::CH_COLON);
    push_pair(hh);
    text_q.push_back(ltt_pkg::CH_COLON);
    push_pair(mi);
    text_q.push_back(ltt_pkg::CH_COLON);
    push_pair(ss);
    text_q.push_back(ltt_pkg::CH_SPACE);
    text_q.push_back(wild ? 8'($urandom_range(0, 255)) : "+");
    repeat (4) text_q.push_back(wild ? 8'($urandom_range(0, 255)) : ltt_pkg::CH_ZERO);
  endtask

  task automatic random_stamp();
    int unsigned mon;
    int unsigned yy;
    int unsigned dd;
    int unsigned hh;
    mon = $urandom_range(0, 11);
    yy  = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) dd = $urandom_range(0, 39);
    else dd = $urandom_range(1, days_in_month(mon, (yy % 4) == 0));
    if ($urandom_range(0, 6) == 0) hh = $urandom_range(0, 29);
    else hh = $urandom_range(0, 23);
    make_stamp(dd, mon, yy, hh, $urandom_range(0, 59), $urandom_range(0, 59),
               $urandom_range(0, 1));
  endtask

  task automatic mutate_text(input mutation_e kind);
    int unsigned p;
    int unsigned n;
    case (kind)
      MUT_TRUNCATE: begin
        n = $urandom_range(1, ltt_pkg::STR_LEN - 1);
        while (text_q.size() > n) text_q.delete(text_q.size() - 1);
      end
      MUT_EXTEND: begin
        n = $urandom_range(1, 14);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      end
      MUT_REPLACE: begin
        // Half the time pick a byte from the digit range or its two neighbors to probe its edges.
        p = $urandom_range(0, ltt_pkg::STR_LEN - 1);
        if ($urandom_range(0, 1)) text_q[p] = 8'($urandom_range(0, 255));
        else text_q[p] = 8'($urandom_range(ltt_pkg::CH_SLASH, ltt_pkg::CH_COLON));
      end
      MUT_CASE: begin
        p = $urandom_range(3, 5);
        text_q[p] = text_q[p] ^ 8'h20;
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned n;
    sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    make_stamp(1, 0, 0, 0, 0, 0, 1'b0);
    send_text();
    make_stamp(31, 11, 99, 23, 59, 59, 1'b1);
    send_text();
    make_stamp(29, 1, 24, 12, 30, 30, 1'b0);
    send_text();
    make_stamp(29, 1, 23, 12, 30, 30, 1'b0);
    send_text();
    make_stamp(0, 2, 10, 8, 0, 0, 1'b0);
    send_text();
    make_stamp(31, 3, 11, 8, 0, 0, 1'b0);
    send_text();
    make_stamp(15, 5, 15, 24, 0, 0, 1'b0);
    send_text();
    text_q.delete();
    text_q.push_back(ltt_pkg::CH_NINE);
    send_text();

    hold_request = 1'b1;
    while (chars_sent < MIN_CHARS || strings_sent < MIN_STRINGS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        random_stamp();
      end else if (pick < 9) begin
        random_stamp();
        mutate_text(mutation_e'($urandom_range(MUT_TRUNCATE, MUT_CASE)));
      end else begin
        text_q.delete();
        n = $urandom_range(1, 30);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
